// ===== src/sknn_pkg.sv =====
// shared types and constants of the segment k-nearest-neighbor block
package sknn_pkg;

  localparam int MAX_NEIGHBORS = 16;
  localparam int MAX_FEATURES  = 64;
  localparam int INDEX_BITS    = 20;

  localparam int FEAT_W   = 16;
  localparam int SQ_W     = 2 * FEAT_W;
  localparam int DIST_W   = 38;
  localparam int NC_W     = 5;
  localparam int FC_W     = 7;
  localparam int CFG_W    = (NC_W > FC_W) ? NC_W : FC_W;
  localparam int CFG_IDX_W = 1;
  localparam int POS_W    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int FE_W     = $clog2(MAX_FEATURES + 1);
  localparam int KE_W     = $clog2(MAX_NEIGHBORS + 1);
  localparam int CNT_W    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int OUT_RAW_W  = INDEX_BITS + DIST_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [NC_W-1:0] NC_RESET = NC_W'(16);
  localparam logic [FC_W-1:0] FC_RESET = FC_W'(3);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT  = 1'b1;

  // opcodes of the input word
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_CAND  = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic [DIST_W-1:0]     distance;
    logic [INDEX_BITS-1:0] idx;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } cell_ctrl_t;

  typedef struct packed {
    logic                  ins;
    logic                  last;
    logic [DIST_W-1:0]     distance;
    logic [INDEX_BITS-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic vld;
    logic op;
    logic done;
    logic last;
  } stage_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

// ===== src/sknn_cell.sv =====
// one cell of the sorted neighbor list: holds one entry, inserts and shifts
module sknn_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sknn_pkg::cell_ctrl_t ctrl,
  input  sknn_pkg::entry_t    cand,
  input  sknn_pkg::entry_t    prev,
  input  logic                prev_take,
  input  sknn_pkg::entry_t    next,
  output sknn_pkg::entry_t    ent,
  output logic                take
);

  logic                            vld_r, vld_nxt;
  logic [sknn_pkg::DIST_W-1:0]     dist_r, dist_nxt;
  logic [sknn_pkg::INDEX_BITS-1:0] idx_r, idx_nxt;

  // strict compare keeps the earlier candidate ahead on a tie
  assign take = !vld_r || (dist_r > cand.distance);

  assign ent.valid    = vld_r;
  assign ent.distance = dist_r;
  assign ent.idx      = idx_r;

  always_comb begin
    vld_nxt  = vld_r;
    dist_nxt = dist_r;
    idx_nxt  = idx_r;
    if (ctrl.clr) begin
      vld_nxt = 1'b0;
    end else if (ctrl.ins && take) begin
      if (prev_take) begin
        vld_nxt  = prev.valid;
        dist_nxt = prev.distance;
        idx_nxt  = prev.idx;
      end else begin
        vld_nxt  = 1'b1;
        dist_nxt = cand.distance;
        idx_nxt  = cand.idx;
      end
    end else if (ctrl.shift) begin
      vld_nxt  = next.valid;
      dist_nxt = next.distance;
      idx_nxt  = next.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    idx_r  <= idx_nxt;
  end

endmodule

// ===== src/sknn_dist.sv =====
// distance pipeline: query store, difference, square and accumulation
module sknn_dist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic                         op,
  input  logic [sknn_pkg::FEAT_W-1:0]  value,
  input  logic                         last,
  input  logic [sknn_pkg::FE_W-1:0]    f_eff,
  output sknn_pkg::cand_t              cand
);

  logic [sknn_pkg::FEAT_W-1:0]     qmem [sknn_pkg::MAX_FEATURES];
  logic [sknn_pkg::MAX_FEATURES-1:0] qv_r;

  logic [sknn_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic                            done_a;

  sknn_pkg::stage_t                a_r, b_r, c_r;
  logic [sknn_pkg::FEAT_W-1:0]     rd_r, va_r;
  logic                            rdv_r;
  logic [sknn_pkg::FEAT_W-1:0]     q, ad, ad_r;
  logic signed [sknn_pkg::FEAT_W:0] d;
  logic [sknn_pkg::SQ_W-1:0]       sq_r;

  logic [sknn_pkg::DIST_W-1:0]     sum_r, sum_nxt, snew;
  logic [sknn_pkg::DIST_W:0]       ssum;
  logic [sknn_pkg::INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic                            is_cand, seg_end;

  // one position counter shared by query and candidate features
  assign done_a = (sknn_pkg::FE_W'({1'b0, pos_r}) + sknn_pkg::FE_W'(1)) >= f_eff;

  always_comb begin
    pos_nxt = pos_r;
    if (acc) begin
      pos_nxt = (done_a || last) ? '0 : pos_r + sknn_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (op == sknn_pkg::OP_QUERY)) begin
      qmem[pos_r] <= value;
    end
    if (acc) begin
      rd_r  <= qmem[pos_r];
      rdv_r <= qv_r[pos_r];
      va_r  <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r <= '0;
    end else if (acc && (op == sknn_pkg::OP_QUERY)) begin
      qv_r[pos_r] <= 1'b1;
    end
  end

  // never written query features read as zero
  assign q = rdv_r ? rd_r : '0;
  assign d = $signed({va_r[sknn_pkg::FEAT_W-1], va_r}) - $signed({q[sknn_pkg::FEAT_W-1], q});
  always_comb begin
    if (d[sknn_pkg::FEAT_W]) begin
      ad = sknn_pkg::FEAT_W'(-d);
    end else begin
      ad = sknn_pkg::FEAT_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    ad_r <= ad;
    sq_r <= ad_r * ad_r;
  end

  assign is_cand = c_r.vld && (c_r.op == sknn_pkg::OP_CAND);
  assign seg_end = c_r.vld && c_r.last;
  assign ssum    = {1'b0, sum_r} + (sknn_pkg::DIST_W + 1)'(sq_r);
  assign snew    = ssum[sknn_pkg::DIST_W] ? sknn_pkg::DIST_MAX : ssum[sknn_pkg::DIST_W-1:0];

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (is_cand) begin
      sum_nxt = c_r.done ? '0 : snew;
      if (c_r.done) begin
        cnt_nxt = cnt_r + sknn_pkg::INDEX_BITS'(1);
      end
    end
    // a partial candidate is dropped at segment end
    if (seg_end) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end
  end

  assign cand.ins      = is_cand && c_r.done;
  assign cand.last     = seg_end;
  assign cand.distance = snew;
  assign cand.idx      = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
      a_r   <= '0;
      b_r   <= '0;
      c_r   <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      a_r   <= '{vld: acc, op: op, done: done_a, last: last};
      b_r   <= a_r;
      c_r   <= b_r;
    end
  end

endmodule

// ===== src/segment_knn_top_k.sv =====
// top level: config registers, neighbor cell chain and result sequencer
// A segment streams in as words of one feature each: the query vector first
// (tuser 0), then every candidate vector including the query again (tuser 1),
// with tlast on the segment's final word. Words are taken one per cycle while the
// input is open; a finished candidate distance leaves the four-stage distance pipeline
// (query store read, difference, square, accumulate) and is sorted into a chain of
// MAX_NEIGHBORS list cells in that same cycle. After tlast the input stalls while
// the pipeline drains, then k result words are sent from the head of the cell chain,
// one per cycle while out_tready is high, the chain moving up one cell per word;
// input resumes the cycle after the final result.
// No clearing pass is needed after reset.
module segment_knn_top_k (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sknn_pkg::FEAT_W-1:0]        in_tdata,   // feature_value
  input  logic                               in_tuser,   // opcode
  input  logic                               in_tlast,   // last_in_segment
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sknn_pkg::OUT_DATA_W-1:0]    out_tdata,  // neighbor_index, neighbor_distance, zero pad
  output logic                               out_tuser,  // slot_valid
  output logic                               out_tlast,  // last_result
  input  logic                               cfg_we,
  input  logic [sknn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sknn_pkg::CFG_W-1:0]         cfg_data
);

  localparam int N = sknn_pkg::MAX_NEIGHBORS;

  logic [sknn_pkg::NC_W-1:0]  nc_r;
  logic [sknn_pkg::FC_W-1:0]  fc_r;
  logic [sknn_pkg::KE_W-1:0]  k_eff;
  logic [sknn_pkg::FE_W-1:0]  f_eff;

  sknn_pkg::state_t           state_r, state_nxt;
  logic [sknn_pkg::CNT_W-1:0] ecnt_r, ecnt_nxt;
  logic                       in_acc, out_acc, final_res;

  sknn_pkg::cand_t            cand;
  sknn_pkg::entry_t           cand_ent;
  sknn_pkg::cell_ctrl_t       ctrl;
  sknn_pkg::entry_t           ent   [N];
  sknn_pkg::entry_t           prv   [N];
  sknn_pkg::entry_t           nxt   [N];
  logic                       take  [N];
  logic                       ptake [N];
  logic [N-1:0]               vld_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= sknn_pkg::NC_RESET;
      fc_r <= sknn_pkg::FC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sknn_pkg::CFG_NEIGHBOR_COUNT: nc_r <= cfg_data[sknn_pkg::NC_W-1:0];
        sknn_pkg::CFG_FEATURE_COUNT:  fc_r <= cfg_data[sknn_pkg::FC_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range register values are clamped
  always_comb begin
    if (nc_r == '0) begin
      k_eff = sknn_pkg::KE_W'(1);
    end else if (32'(nc_r) > N) begin
      k_eff = sknn_pkg::KE_W'(N);
    end else begin
      k_eff = sknn_pkg::KE_W'(nc_r);
    end
    if (fc_r == '0) begin
      f_eff = sknn_pkg::FE_W'(1);
    end else if (32'(fc_r) > sknn_pkg::MAX_FEATURES) begin
      f_eff = sknn_pkg::FE_W'(sknn_pkg::MAX_FEATURES);
    end else begin
      f_eff = sknn_pkg::FE_W'(fc_r);
    end
  end

  assign in_tready  = (state_r == sknn_pkg::ST_RUN);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == sknn_pkg::ST_EMIT);
  assign out_acc    = out_tvalid && out_tready;
  assign final_res  = (sknn_pkg::KE_W'(ecnt_r) + sknn_pkg::KE_W'(1)) == k_eff;

  sknn_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .op    (in_tuser),
    .value (in_tdata),
    .last  (in_tlast),
    .f_eff (f_eff),
    .cand  (cand)
  );

  always_comb begin
    state_nxt = state_r;
    ecnt_nxt  = ecnt_r;
    unique case (state_r)
      sknn_pkg::ST_RUN: begin
        if (in_acc && in_tlast) begin
          state_nxt = sknn_pkg::ST_DRAIN;
        end
      end
      sknn_pkg::ST_DRAIN: begin
        if (cand.last) begin
          state_nxt = sknn_pkg::ST_EMIT;
          ecnt_nxt  = '0;
        end
      end
      sknn_pkg::ST_EMIT: begin
        if (out_acc) begin
          if (final_res) begin
            state_nxt = sknn_pkg::ST_RUN;
          end else begin
            ecnt_nxt = ecnt_r + sknn_pkg::CNT_W'(1);
          end
        end
      end
      default: state_nxt = sknn_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sknn_pkg::ST_RUN;
      ecnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ecnt_r  <= ecnt_nxt;
    end
  end

  assign ctrl.ins   = cand.ins;
  assign ctrl.shift = out_acc && !final_res;
  assign ctrl.clr   = out_acc && final_res;

  assign cand_ent.valid    = 1'b1;
  assign cand_ent.distance = cand.distance;
  assign cand_ent.idx      = cand.idx;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign prv[gi]   = '0;
        assign ptake[gi] = 1'b0;
      end else begin : g_mid
        assign prv[gi]   = ent[gi-1];
        assign ptake[gi] = take[gi-1];
      end
      if (gi == N - 1) begin : g_tail
        assign nxt[gi] = '0;
      end else begin : g_body
        assign nxt[gi] = ent[gi+1];
      end
      assign vld_vec[gi] = ent[gi].valid;

      sknn_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cand      (cand_ent),
        .prev      (prv[gi]),
        .prev_take (ptake[gi]),
        .next      (nxt[gi]),
        .ent       (ent[gi]),
        .take      (take[gi])
      );
    end
  endgenerate

  // empty slots report zero index and distance
  assign out_tdata = {{(sknn_pkg::OUT_DATA_W - sknn_pkg::OUT_RAW_W){1'b0}},
                      (ent[0].valid ? ent[0].distance : '0),
                      (ent[0].valid ? ent[0].idx  : '0)};
  assign out_tuser = ent[0].valid;
  assign out_tlast = final_res;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("result sent while input is open");

  a_back_to_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("block did not return to input after final result");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec & (vld_vec + N'(1))) == '0))
    else $error("list cells not filled from the head");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (ent[0].valid && ent[N-1 > 0 ? 1 : 0].valid) |->
      (ent[0].distance <= ent[N-1 > 0 ? 1 : 0].distance))
    else $error("list head out of order");

  a_list_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (vld_vec == '0))
    else $error("list not cleared after emission");

endmodule

// ===== bench/knn_result_check.sv =====
// result checker: predicts each segment's neighbor list and compares every result word
`timescale 1ns / 1ps
module knn_result_check
  import sknn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [FEAT_W-1:0]     in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int ACC_W        = DIST_W + 2;
  localparam int REPORT_LIMIT = 40;

  typedef struct {
    logic [INDEX_BITS-1:0] idx;
    logic [DIST_W-1:0]     distance;
    logic                  valid;
    logic                  is_last;
  } neighbor_t;

  neighbor_t expected_neighbors[$];
  int errors_seen = 0;

  logic [NC_W-1:0]          k_reg;
  logic [FC_W-1:0]          f_reg;
  logic signed [FEAT_W-1:0] query_vec [MAX_FEATURES];
  logic [DIST_W-1:0]        dist_acc;
  int unsigned              feat_pos;
  logic [INDEX_BITS-1:0]    cand_num;
  logic [DIST_W-1:0]        list_dist [MAX_NEIGHBORS];
  logic [INDEX_BITS-1:0]    list_idx [MAX_NEIGHBORS];
  logic                     list_valid [MAX_NEIGHBORS];

  task automatic clear_segment();
    dist_acc = '0;
    feat_pos = 0;
    cand_num = '0;
    foreach (list_valid[i]) list_valid[i] = 1'b0;
  endtask

  // sorted insert; an equal distance lands behind the ones already held
  task automatic sort_in(input logic [DIST_W-1:0] d, input logic [INDEX_BITS-1:0] id);
    int n;
    int pos;
    int i;
    n = 0;
    while (n < MAX_NEIGHBORS && list_valid[n]) n++;
    pos = n;
    for (i = 0; i < n; i++) begin
      if (list_dist[i] > d) begin
        pos = i;
        break;
      end
    end
    if (pos >= MAX_NEIGHBORS) return;
    i = (n < MAX_NEIGHBORS) ? n : MAX_NEIGHBORS - 1;
    while (i > pos) begin
      list_dist[i]  = list_dist[i-1];
      list_idx[i]   = list_idx[i-1];
      list_valid[i] = list_valid[i-1];
      i--;
    end
    list_dist[pos]  = d;
    list_idx[pos]   = id;
    list_valid[pos] = 1'b1;
  endtask

  task automatic advance_search(input logic op, input logic signed [FEAT_W-1:0] v,
                                input logic seg_end);
    int unsigned f;
    int unsigned p;
    int unsigned k;
    int unsigned i;
    longint      diff;
    logic [ACC_W-1:0] total;
    logic        done;
    neighbor_t   r;
    f = (f_reg == 0) ? 1 : (f_reg > MAX_FEATURES) ? MAX_FEATURES : f_reg;
    p = (feat_pos >= MAX_FEATURES) ? MAX_FEATURES - 1 : feat_pos;
    done = (p + 1 >= f);
    if (op == OP_QUERY) begin
      query_vec[p] = v;
    end else begin
      diff = longint'(v) - longint'(query_vec[p]);
      total = ACC_W'(dist_acc) + ACC_W'(diff * diff);
      dist_acc = (total > ACC_W'(DIST_MAX)) ? DIST_MAX : total[DIST_W-1:0];
      if (done) begin
        sort_in(dist_acc, cand_num);
        cand_num = cand_num + 1'b1;
        dist_acc = '0;
      end
    end
    feat_pos = done ? 0 : p + 1;
    if (!seg_end) return;
    k = (k_reg == 0) ? 1 : (k_reg > MAX_NEIGHBORS) ? MAX_NEIGHBORS : k_reg;
    for (i = 0; i < k; i++) begin
      r.valid    = list_valid[i];
      r.idx      = list_valid[i] ? list_idx[i] : '0;
      r.distance = list_valid[i] ? list_dist[i] : '0;
      r.is_last  = (i + 1 == k);
      expected_neighbors.push_back(r);
    end
    clear_segment();
  endtask

  task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                             input logic [DIST_W-1:0] got);
    if (want !== got) begin
      errors_seen++;
      if (errors_seen <= REPORT_LIMIT)
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_word();
    neighbor_t want;
    if (expected_neighbors.size() == 0) begin
      errors_seen++;
      if (errors_seen <= REPORT_LIMIT)
        $display("%0t: result word with nothing expected, expected none got index %0d",
                 $time, out_tdata[INDEX_BITS-1:0]);
      return;
    end
    want = expected_neighbors.pop_front();
    check_field("neighbor_index", DIST_W'(want.idx), DIST_W'(out_tdata[INDEX_BITS-1:0]));
    check_field("neighbor_distance", want.distance, out_tdata[INDEX_BITS +: DIST_W]);
    check_field("slot_valid", DIST_W'(want.valid), DIST_W'(out_tuser));
    check_field("last_result", DIST_W'(want.is_last), DIST_W'(out_tlast));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      k_reg = NC_RESET;
      f_reg = FC_RESET;
      foreach (query_vec[i]) query_vec[i] = '0;
      foreach (list_dist[i]) begin
        list_dist[i] = '0;
        list_idx[i]  = '0;
      end
      clear_segment();
      expected_neighbors.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEIGHBOR_COUNT: k_reg = cfg_data[NC_W-1:0];
          CFG_FEATURE_COUNT:  f_reg = cfg_data[FC_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) advance_search(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_word();
    end
    pending    <= expected_neighbors.size();
    fail_count <= errors_seen;
  end

endmodule

// ===== bench/tb_top.sv =====
// testbench top: clock, reset, segment stimulus, result-side stalls and verdict
`timescale 1ns / 1ps
module tb_top;
  import sknn_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_HOLD     = 150;
  localparam int WORD_TARGET   = 330;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [FEAT_W-1:0]     in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_data   = '0;

  int fail_count;
  int pending;
  int feat_n          = 3;
  int words_sent      = 0;
  int burst_left      = 0;
  bit long_hold_armed = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  segment_knn_top_k dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  knn_result_check u_result_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic logic [FEAT_W-1:0] pick_feature();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3, 4:    return FEAT_W'($urandom_range(0, 16)) - 16'd8;
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  // one word on the input channel; bursts of random length with random gaps
  task automatic send_word(input logic op, input logic [FEAT_W-1:0] val, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= op;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // stop sending and wait until every expected result word is out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] raw_k, input logic [CFG_W-1:0] raw_f);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NEIGHBOR_COUNT;
    cfg_data  <= raw_k;
    @(posedge clk);
    cfg_index <= CFG_FEATURE_COUNT;
    cfg_data  <= raw_f;
    @(posedge clk);
    cfg_we    <= 1'b0;
    feat_n = (raw_f == 0) ? 1 : (raw_f > MAX_FEATURES) ? MAX_FEATURES : raw_f;
  endtask

  task automatic well_formed_segment(input int n_cand);
    logic [FEAT_W-1:0] qv [MAX_FEATURES];
    logic [FEAT_W-1:0] pv [MAX_FEATURES];
    logic [FEAT_W-1:0] val;
    int self_at;
    int style;
    int c;
    int j;
    for (j = 0; j < feat_n; j++) begin
      qv[j] = pick_feature();
      send_word(OP_QUERY, qv[j], n_cand == 0 && j == feat_n - 1);
    end
    self_at = (n_cand > 0) ? $urandom_range(0, n_cand - 1) : 0;
    for (c = 0; c < n_cand; c++) begin
      // 0 fresh, 1 close to the query, 2 copy of previous (tie), 3 the query itself
      style = (c == self_at) ? 3 : $urandom_range(0, 2);
      if (style == 2 && c == 0) style = 0;
      for (j = 0; j < feat_n; j++) begin
        case (style)
          0:       val = pick_feature();
          1:       val = qv[j] + FEAT_W'($urandom_range(0, 6)) - 16'd3;
          2:       val = pv[j];
          default: val = qv[j];
        endcase
        pv[j] = val;
        send_word(OP_CAND, val, c == n_cand - 1 && j == feat_n - 1);
      end
    end
  endtask

  // random opcodes, vectors cut anywhere, segment ends where it falls
  task automatic broken_segment();
    int n;
    int i;
    n = $urandom_range(1, 2 * feat_n + 3);
    for (i = 0; i < n; i++)
      send_word(logic'($urandom_range(0, 1)), pick_feature(), i == n - 1);
  endtask

  task automatic random_phase(input int n_seg);
    int s;
    int n_cand;
    for (s = 0; s < n_seg; s++) begin
      if (s > 0 && $urandom_range(0, 5) == 0) begin
        broken_segment();
      end else begin
        n_cand = (feat_n <= 2 && $urandom_range(0, 3) == 0) ? $urandom_range(12, 20)
                                                            : $urandom_range(0, 6);
        well_formed_segment(n_cand);
      end
    end
  endtask

  initial begin : stimulus
    int j;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes: k 16, three features; extremes, self match and a tie
    send_word(OP_QUERY, 16'h8000, 1'b0);
    send_word(OP_QUERY, 16'h7FFF, 1'b0);
    send_word(OP_QUERY, 16'h0000, 1'b0);
    send_word(OP_CAND, 16'h7FFF, 1'b0);
    send_word(OP_CAND, 16'h8000, 1'b0);
    send_word(OP_CAND, 16'h0000, 1'b0);
    send_word(OP_CAND, 16'h8000, 1'b0);
    send_word(OP_CAND, 16'h7FFF, 1'b0);
    send_word(OP_CAND, 16'h0000, 1'b0);
    send_word(OP_CAND, 16'h8000, 1'b0);
    send_word(OP_CAND, 16'h7FFF, 1'b0);
    send_word(OP_CAND, 16'h0001, 1'b0);
    send_word(OP_CAND, 16'h8000, 1'b0);
    send_word(OP_CAND, 16'h7FFF, 1'b0);
    send_word(OP_CAND, 16'hFFFF, 1'b1);
    // segment end on a query word with an empty list
    send_word(OP_QUERY, 16'h1234, 1'b1);
    // opcode switch inside a vector, then a cut-off candidate at segment end
    send_word(OP_QUERY, 16'h00FF, 1'b0);
    send_word(OP_CAND, 16'h0100, 1'b0);
    send_word(OP_CAND, 16'hFF00, 1'b0);
    send_word(OP_CAND, 16'h7FFF, 1'b0);
    send_word(OP_CAND, 16'h8000, 1'b1);

    settle();
    set_config(7'h00, 7'h01);
    long_hold_armed = 1'b1;
    random_phase(6);

    // oversized registers clamp to the maximum; largest possible distance
    settle();
    set_config(7'h7F, 7'h7F);
    for (j = 0; j < feat_n; j++)
      send_word(OP_QUERY, (j % 2 == 0) ? 16'h8000 : 16'h7FFF, 1'b0);
    for (j = 0; j < feat_n; j++)
      send_word(OP_CAND, (j % 2 == 0) ? 16'h7FFF : 16'h8000, j == feat_n - 1);

    // leave a vector half done so the next, smaller feature count sees a high position
    settle();
    set_config(7'h05, 7'h08);
    random_phase(1);
    for (j = 0; j < 5; j++) send_word(OP_QUERY, pick_feature(), 1'b0);

    settle();
    set_config(7'h02, 7'h02);
    random_phase(3);

    settle();
    set_config(7'h10, 7'h00);
    random_phase(3);

    while (words_sent < WORD_TARGET) begin
      settle();
      set_config(CFG_W'($urandom), CFG_W'($urandom_range(0, 4)));
      random_phase($urandom_range(2, 4));
    end

    settle();
    if (fail_count == 0)
      $display("** segment_knn_top_k: PASSED **");
    else
      $display("** segment_knn_top_k: FAILED **");
    $finish;
  end

  // result side: random stall patterns that change from time to time, one long hold-off
  initial begin : receiver
    int mode;
    int mode_left;
    bit hold_done;
    logic rdy;
    mode_left = 0;
    hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_armed && !hold_done && out_tvalid) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = logic'($urandom_range(0, 1));
          2:       rdy = ($urandom_range(0, 4) != 0);
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
        out_tready <= rdy;
        @(posedge clk);
      end
    end
  end

  // ends the run if no word moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** segment_knn_top_k: FAILED **");
    $finish;
  end

endmodule

// ===== segment_knn_top_k.f =====
src/sknn_pkg.sv
src/sknn_cell.sv
src/sknn_dist.sv
src/segment_knn_top_k.sv
bench/knn_result_check.sv
bench/tb_top.sv
